@@ sv/prq_pkg.sv @@
// Shared types and constants for the priority ready queue.
`default_nettype none
package prq_pkg;

    localparam int KIND_W   = 3;
    localparam int TASK_W   = 6;
    localparam int PRIO_W   = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQUEUE = 3'd0,
        KIND_DEQUEUE = 3'd1,
        KIND_PEEK    = 3'd2,
        KIND_REMOVE  = 3'd3,
        KIND_MOVE    = 3'd4,
        KIND_CLEAR   = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TOP_SCAN,
        S_TOP_READ,
        S_TOP_TAKE,
        S_DROP_READ,
        S_DROP_WRITE,
        S_ADD_READ,
        S_ADD_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic wipe;
        logic refuse;
        logic top_scan;
        logic head_read;
        logic top_take;
        logic drop_read;
        logic drop_write;
        logic add_read;
        logic add_write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_enq;
        logic is_deq;
        logic is_peek;
        logic is_rem;
        logic is_move;
        logic is_clear;
        logic tvalid;
        logic queued;
        logic same;
        logic grp_any;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ sv/prq_if.sv @@
// Request and response channel interfaces of the priority ready queue.
`default_nettype none
interface prq_req_if import prq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [TASK_W-1:0]   task_id;
    logic [PRIO_W-1:0]   priority_req;
    logic [PRIO_W-1:0]   old_priority;

    modport source (output valid, kind, task_id, priority_req, old_priority, input ready);
    modport sink (input valid, kind, task_id, priority_req, old_priority, output ready);
endinterface

interface prq_rsp_if import prq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [TASK_W-1:0]   out_task;
    logic                found;
    logic [STATUS_W-1:0] status;

    modport source (output valid, out_task, found, status, input ready);
    modport sink (input valid, out_task, found, status, output ready);
endinterface
`default_nettype wire

@@ sv/priority_ready_queue.sv @@
// Top level of the priority ready queue: one FIFO of task numbers per level.
//
// Requests arrive on i_req (valid/ready); each request gives exactly one
// response on o_rsp (valid/ready) with out_task, found and status.
// Kinds: enqueue, dequeue highest, peek highest, remove, move, clear all.
// Queues are linked lists in small single-port memories; a bitmap of
// non-empty levels is scanned in two registered steps (group of eight
// levels, then the level inside the group).
// Refused or trivial requests, clear all, same-level move and remove of an
// unqueued task go from decode straight to the response; the others pass
// through the top scan, head read and take steps and/or the drop and add
// steps as their kind needs. Link reads are registered, so each memory step
// is its own state. One request is in work at a time; the next is taken the
// cycle after the response register loads.
// Reset empties every level and marks every task unqueued at once; link
// memories need no clearing.
// When the receiver stalls, the response holds in the output register and
// the next request is processed up to its own response, then waits.
`default_nettype none
module priority_ready_queue import prq_pkg::*; #(
    parameter int PRIORITY_CEILING = 127,
    parameter int MAX_TASKS        = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    prq_req_if.sink    i_req,
    prq_rsp_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_req_ready (i_req.ready)
    );

    prq_dp #(
        .PRIORITY_CEILING (PRIORITY_CEILING),
        .MAX_TASKS        (MAX_TASKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_kind         (i_req.kind),
        .i_task_id      (i_req.task_id),
        .i_priority_req (i_req.priority_req),
        .i_old_priority (i_req.old_priority),
        .i_rsp_ready    (o_rsp.ready),
        .o_sts          (w_sts),
        .o_rsp_valid    (o_rsp.valid),
        .o_out_task     (o_rsp.out_task),
        .o_found        (o_rsp.found),
        .o_status       (o_rsp.status)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while previous one in work");

    a_one_write_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.drop_write, w_cmd.add_read, w_cmd.add_write, w_cmd.wipe}))
        else $error("conflicting memory write steps");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.found |-> o_rsp.status == ST_OK)
        else $error("found response with error status");

    a_load_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> i_req.ready)
        else $error("load outside idle");

endmodule
`default_nettype wire

@@ sv/prq_ctrl.sv @@
// Sequencer that steps the queue datapath through each request.
`default_nettype none
module prq_ctrl import prq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_req_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                priority if (i_sts.is_enq) begin
                    n_state = (i_sts.tvalid && !i_sts.queued) ? S_ADD_READ : S_DONE;
                end else if (i_sts.is_deq || i_sts.is_peek) begin
                    n_state = S_TOP_SCAN;
                end else if (i_sts.is_rem) begin
                    n_state = (i_sts.tvalid && i_sts.queued) ? S_DROP_READ : S_DONE;
                end else if (i_sts.is_move && i_sts.tvalid && !i_sts.same) begin
                    n_state = i_sts.queued ? S_DROP_READ : S_ADD_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TOP_SCAN:   n_state = S_TOP_READ;
            S_TOP_READ:   n_state = i_sts.grp_any ? S_TOP_TAKE : S_DONE;
            S_TOP_TAKE:   n_state = i_sts.is_deq ? S_DROP_READ : S_DONE;
            S_DROP_READ:  n_state = S_DROP_WRITE;
            S_DROP_WRITE: n_state = i_sts.is_move ? S_ADD_READ : S_DONE;
            S_ADD_READ:   n_state = S_ADD_WRITE;
            S_ADD_WRITE:  n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_DECODE: begin
                o_cmd.refuse = i_sts.is_enq && i_sts.tvalid && i_sts.queued;
                o_cmd.wipe   = i_sts.is_clear;
            end
            S_TOP_SCAN:   o_cmd.top_scan   = 1'b1;
            S_TOP_READ:   o_cmd.head_read  = 1'b1;
            S_TOP_TAKE:   o_cmd.top_take   = 1'b1;
            S_DROP_READ:  o_cmd.drop_read  = 1'b1;
            S_DROP_WRITE: o_cmd.drop_write = 1'b1;
            S_ADD_READ:   o_cmd.add_read   = 1'b1;
            S_ADD_WRITE:  o_cmd.add_write  = 1'b1;
            S_DONE:       o_cmd.out_load   = i_sts.out_free;
            default:      o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/prq_dp.sv @@
// Level lists, link memories, top-level search and response register.
`default_nettype none
module prq_dp import prq_pkg::*; #(
    parameter int PRIORITY_CEILING = 127,
    parameter int MAX_TASKS        = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [TASK_W-1:0]   i_task_id,
    input  wire logic [PRIO_W-1:0]   i_priority_req,
    input  wire logic [PRIO_W-1:0]   i_old_priority,
    input  wire logic                i_rsp_ready,
    output t_sts                     o_sts,
    output logic                     o_rsp_valid,
    output logic [TASK_W-1:0]        o_out_task,
    output logic                     o_found,
    output logic [STATUS_W-1:0]      o_status
);

    localparam int NLEV  = PRIORITY_CEILING + 1;
    localparam int LW    = $clog2(NLEV);
    localparam int NTASK = (MAX_TASKS < 64) ? MAX_TASKS : 64;
    localparam int TW    = $clog2(NTASK);
    localparam int NGRP  = (NLEV + 7) / 8;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int NPAD  = NGRP * 8;

    // pointer: msb set means null
    logic [TW:0]        m_next  [NTASK];
    logic [TW:0]        m_prev  [NTASK];
    logic [LW-1:0]      m_level [NTASK];
    logic [TW-1:0]      m_head  [NLEV];
    logic [TW-1:0]      m_tail  [NLEV];

    logic [KIND_W-1:0]   r_kind;
    logic [TW-1:0]       r_task;
    logic                r_tvalid;
    logic [LW-1:0]       r_newlv;
    logic                r_same;
    logic [NLEV-1:0]     r_nonempty;
    logic [NTASK-1:0]    r_queued;
    logic [GW-1:0]       r_grp;
    logic                r_grp_any;
    logic [TW-1:0]       r_head_q;
    logic [TW-1:0]       r_tail_q;
    logic [TW:0]         r_next_q;
    logic [TW:0]         r_prev_q;
    logic [LW-1:0]       r_level_q;
    logic [TASK_W-1:0]   r_otask;
    logic                r_found;
    logic [STATUS_W-1:0] r_status;
    logic                r_out_valid;
    logic [TASK_W-1:0]   r_rsp_task;
    logic                r_rsp_found;
    logic [STATUS_W-1:0] r_rsp_status;

    logic [NPAD-1:0]     w_pad;
    logic [NGRP-1:0]     w_gany;
    logic [GW-1:0]       w_gsel;
    logic [7:0]          w_gbits;
    logic [2:0]          w_bsel;
    logic [LW-1:0]       w_toplv;
    logic [TW:0]         w_null;
    logic                w_pnull;
    logic                w_nnull;
    logic                w_tlnull;

    assign w_pad   = NPAD'(r_nonempty);
    assign w_null  = {1'b1, TW'(0)};
    assign w_pnull = r_prev_q[TW];
    assign w_nnull = r_next_q[TW];
    assign w_tlnull = !r_nonempty[r_newlv];

    always_comb begin
        w_gsel = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_gany[g] = |w_pad[g*8 +: 8];
            if (w_gany[g]) w_gsel = GW'(g);
        end
    end

    assign w_gbits = w_pad[{r_grp, 3'b000} +: 8];

    always_comb begin
        w_bsel = '0;
        for (int b = 0; b < 8; b++) begin
            if (w_gbits[b]) w_bsel = 3'(b);
        end
    end

    assign w_toplv = LW'({r_grp, w_bsel});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_task   <= i_task_id[TW-1:0];
            r_tvalid <= 32'(i_task_id) < 32'(MAX_TASKS);
            r_newlv  <= (32'(i_priority_req) > 32'(PRIORITY_CEILING)) ?
                        LW'(PRIORITY_CEILING) : i_priority_req[LW-1:0];
            r_same   <= i_old_priority == i_priority_req;
            r_otask  <= '0;
            r_found  <= 1'b0;
            r_status <= ST_OK;
        end
        if (i_cmd.refuse) r_status <= ST_REFUSED;
        if (i_cmd.top_scan) begin
            r_grp     <= w_gsel;
            r_grp_any <= |w_gany;
        end
        if (i_cmd.head_read && !r_grp_any) r_status <= ST_EMPTY;
        if (i_cmd.top_take) begin
            r_otask <= TASK_W'(r_head_q);
            r_found <= 1'b1;
            r_task  <= r_head_q;
        end
    end

    // head and tail memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.head_read) r_head_q <= m_head[w_toplv];
        if (i_cmd.add_read)  r_tail_q <= m_tail[r_newlv];
        if (i_cmd.drop_write) begin
            if (w_pnull) m_head[r_level_q] <= r_next_q[TW-1:0];
            if (w_nnull) m_tail[r_level_q] <= r_prev_q[TW-1:0];
        end
        if (i_cmd.add_write) begin
            m_tail[r_newlv] <= r_task;
            if (w_tlnull) m_head[r_newlv] <= r_task;
        end
    end

    // per-task link memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.drop_read) begin
            r_next_q  <= m_next[r_task];
            r_prev_q  <= m_prev[r_task];
            r_level_q <= m_level[r_task];
        end
        if (i_cmd.drop_write) begin
            if (!w_pnull) m_next[r_prev_q[TW-1:0]] <= r_next_q;
            if (!w_nnull) m_prev[r_next_q[TW-1:0]] <= r_prev_q;
        end
        if (i_cmd.add_read) m_next[r_task] <= w_null;
        if (i_cmd.add_write) begin
            m_prev[r_task]  <= w_tlnull ? w_null : {1'b0, r_tail_q};
            m_level[r_task] <= r_newlv;
            if (!w_tlnull) m_next[r_tail_q] <= {1'b0, r_task};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            r_queued   <= '0;
        end else if (i_cmd.wipe) begin
            r_nonempty <= '0;
            r_queued   <= '0;
        end else begin
            if (i_cmd.drop_write) begin
                r_queued[r_task] <= 1'b0;
                if (w_pnull && w_nnull) r_nonempty[r_level_q] <= 1'b0;
            end
            if (i_cmd.add_write) begin
                r_queued[r_task]    <= 1'b1;
                r_nonempty[r_newlv] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp_task   <= r_otask;
            r_rsp_found  <= r_found;
            r_rsp_status <= r_status;
        end
    end

    always_comb begin
        o_sts.is_enq   = r_kind == KIND_ENQUEUE;
        o_sts.is_deq   = r_kind == KIND_DEQUEUE;
        o_sts.is_peek  = r_kind == KIND_PEEK;
        o_sts.is_rem   = r_kind == KIND_REMOVE;
        o_sts.is_move  = r_kind == KIND_MOVE;
        o_sts.is_clear = r_kind == KIND_CLEAR;
        o_sts.tvalid   = r_tvalid;
        o_sts.queued   = r_queued[r_task];
        o_sts.same     = r_same;
        o_sts.grp_any  = r_grp_any;
        o_sts.out_free = !r_out_valid || i_rsp_ready;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_out_task  = r_rsp_task;
    assign o_found     = r_rsp_found;
    assign o_status    = r_rsp_status;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench of the priority ready queue: directed and random requests.
`default_nettype none
module testbench;
    import prq_pkg::*;

    localparam int CEIL  = 127;
    localparam int NTASK = 64;
    localparam int NIL   = NTASK;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TASK_W-1:0] tid;
        logic [PRIO_W-1:0] prio;
        logic [PRIO_W-1:0] oldp;
        bit                typed;
        logic [TASK_W-1:0] e_task;
        logic              e_found;
        logic [STATUS_W-1:0] e_status;
    } t_row;

    typedef struct {
        logic [TASK_W-1:0]   out_task;
        logic                found;
        logic [STATUS_W-1:0] status;
    } t_resp;

    logic i_clk;
    logic i_rst_n;
    prq_req_if req_if ();
    prq_rsp_if rsp_if ();

    priority_ready_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    bit       lvl_busy [CEIL+1];
    int       lvl_head [CEIL+1];
    int       lvl_tail [CEIL+1];
    int       nxt      [NTASK];
    int       prv      [NTASK];
    bit       queued   [NTASK];
    int       tlevel   [NTASK];

    t_resp    pending_resp [$];
    int       errors;
    int       send_idle;
    int       recv_stall;

    function automatic void queue_empty_all();
        for (int i = 0; i <= CEIL; i++) begin
            lvl_busy[i] = 0;
            lvl_head[i] = NIL;
            lvl_tail[i] = NIL;
        end
        for (int i = 0; i < NTASK; i++) begin
            queued[i] = 0;
            tlevel[i] = 0;
        end
    endfunction

    function automatic void queue_unlink(int t);
        int lv;
        int p;
        int n;
        lv = tlevel[t];
        p = prv[t];
        n = nxt[t];
        if (p < NTASK) nxt[p] = n;
        else lvl_head[lv] = n;
        if (n < NTASK) prv[n] = p;
        else lvl_tail[lv] = p;
        if (lvl_head[lv] >= NTASK) lvl_busy[lv] = 0;
    endfunction

    function automatic void queue_drop(int t);
        if (queued[t]) queue_unlink(t);
        queued[t] = 0;
        tlevel[t] = 0;
    endfunction

    function automatic int queue_add(int t, int lv);
        int tl;
        if (queued[t]) return 1;
        if (lv > CEIL) lv = CEIL;
        tl = lvl_tail[lv];
        nxt[t] = NIL;
        prv[t] = tl;
        if (tl < NTASK) nxt[tl] = t;
        else lvl_head[lv] = t;
        lvl_tail[lv] = t;
        lvl_busy[lv] = 1;
        tlevel[t] = lv;
        queued[t] = 1;
        return 0;
    endfunction

    function automatic t_resp queue_apply(logic [KIND_W-1:0] kind, int t, int nl, int ol);
        t_resp r;
        int lv;
        r = '{0, 0, ST_OK};
        case (kind)
            KIND_ENQUEUE: if (queue_add(t, nl) != 0) r.status = ST_REFUSED;
            KIND_DEQUEUE, KIND_PEEK: begin
                lv = -1;
                for (int i = CEIL; i >= 0; i--) begin
                    if (lvl_busy[i] && lv < 0) lv = i;
                end
                if (lv < 0 || lvl_head[lv] >= NTASK) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.out_task = TASK_W'(lvl_head[lv]);
                    r.found = 1;
                    if (kind == KIND_DEQUEUE) queue_drop(lvl_head[lv]);
                end
            end
            KIND_REMOVE: queue_drop(t);
            KIND_MOVE: if (ol != nl) begin
                queue_drop(t);
                void'(queue_add(t, nl));
            end
            KIND_CLEAR: queue_empty_all();
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            rsp_if.ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_resp.size() == 0) begin
                $error("response with none expected");
                errors++;
            end else begin
                e = pending_resp[0];
                pending_resp.delete(0);
                if (rsp_if.out_task !== e.out_task) begin
                    $error("out_task expected %0d actual %0d", e.out_task, rsp_if.out_task);
                    errors++;
                end
                if (rsp_if.found !== e.found) begin
                    $error("found expected %0d actual %0d", e.found, rsp_if.found);
                    errors++;
                end
                if (rsp_if.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, rsp_if.status);
                    errors++;
                end
            end
        end
    end

    task automatic send_request(t_row row);
        t_resp p;
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= row.kind;
        req_if.task_id      <= row.tid;
        req_if.priority_req <= row.prio;
        req_if.old_priority <= row.oldp;
        do @(posedge i_clk); while (!req_if.ready);
        p = queue_apply(row.kind, int'(row.tid), int'(row.prio), int'(row.oldp));
        if (row.typed && (p.out_task !== row.e_task || p.found !== row.e_found
                || p.status !== row.e_status)) begin
            $error("typed row disagrees: task %0d found %0d status %0d",
                   p.out_task, p.found, p.status);
            errors++;
        end
        pending_resp = {pending_resp, p};
    endtask

    function automatic t_row random_request(int hot);
        t_row r;
        int pick;
        r.typed = 0;
        r.tid  = (hot != 0) ? TASK_W'($urandom_range(7)) : TASK_W'($urandom_range(63));
        r.prio = ($urandom_range(3) == 0) ? PRIO_W'($urandom_range(127))
                                          : PRIO_W'(120 + $urandom_range(7));
        r.oldp = ($urandom_range(2) == 0) ? r.prio : PRIO_W'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 38) r.kind = KIND_ENQUEUE;
        else if (pick < 60) r.kind = KIND_DEQUEUE;
        else if (pick < 72) r.kind = KIND_PEEK;
        else if (pick < 84) r.kind = KIND_REMOVE;
        else if (pick < 97) r.kind = KIND_MOVE;
        else if (pick < 99) r.kind = KIND_CLEAR;
        else r.kind = KIND_W'(6 + $urandom_range(1));
        return r;
    endfunction

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    t_row directed [24] = '{
        '{KIND_DEQUEUE, 0, 0, 0, 1, 0, 0, ST_EMPTY},
        '{KIND_PEEK, 0, 0, 0, 1, 0, 0, ST_EMPTY},
        '{KIND_ENQUEUE, 63, 127, 0, 1, 0, 0, ST_OK},
        '{KIND_ENQUEUE, 63, 5, 0, 1, 0, 0, ST_REFUSED},
        '{KIND_ENQUEUE, 0, 0, 0, 1, 0, 0, ST_OK},
        '{KIND_ENQUEUE, 21, 127, 0, 0, 0, 0, ST_OK},
        '{KIND_ENQUEUE, 42, 0, 127, 0, 0, 0, ST_OK},
        '{KIND_PEEK, 0, 0, 0, 1, 63, 1, ST_OK},
        '{KIND_DEQUEUE, 0, 0, 0, 1, 63, 1, ST_OK},
        '{KIND_MOVE, 42, 85, 85, 0, 0, 0, ST_OK},
        '{KIND_MOVE, 42, 85, 0, 0, 0, 0, ST_OK},
        '{KIND_MOVE, 7, 100, 1, 0, 0, 0, ST_OK},
        '{KIND_REMOVE, 21, 0, 0, 0, 0, 0, ST_OK},
        '{KIND_REMOVE, 21, 0, 0, 0, 0, 0, ST_OK},
        '{KIND_REMOVE, 33, 0, 0, 0, 0, 0, ST_OK},
        '{3'd6, 63, 127, 127, 1, 0, 0, ST_OK},
        '{3'd7, 0, 0, 0, 1, 0, 0, ST_OK},
        '{KIND_PEEK, 0, 0, 0, 0, 0, 0, ST_OK},
        '{KIND_DEQUEUE, 0, 0, 0, 0, 0, 0, ST_OK},
        '{KIND_DEQUEUE, 0, 0, 0, 0, 0, 0, ST_OK},
        '{KIND_DEQUEUE, 0, 0, 0, 0, 0, 0, ST_OK},
        '{KIND_ENQUEUE, 9, 64, 0, 0, 0, 0, ST_OK},
        '{KIND_CLEAR, 0, 0, 0, 1, 0, 0, ST_OK},
        '{KIND_DEQUEUE, 0, 0, 0, 1, 0, 0, ST_EMPTY}
    };

    initial begin
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 0;
        req_if.valid = 0;
        req_if.kind = KIND_ENQUEUE;
        req_if.task_id = 0;
        req_if.priority_req = 0;
        req_if.old_priority = 0;
        rsp_if.ready = 0;
        queue_empty_all();
        for (int i = 0; i < NTASK; i++) begin
            nxt[i] = 0;
            prv[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_request(directed[i]);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 66; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 66; end
                3: begin send_idle = 35; recv_stall = 35; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            for (int n = 0; n < 325; n++) begin
                send_request(random_request(ph % 2));
                if (n == 160) drain();
            end
        end

        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
